>>> design/cau_pkg.sv
// Shared types, constants and the divide / square-root step for the complex ALU.
package cau_pkg;

   localparam int WORD_BITS = 16;
   localparam int FRAC_BITS = 8;
   localparam int PW = 2 * WORD_BITS;   // product / magnitude width
   localparam int SW = PW + 1;          // signed sum of two products
   localparam int QW = WORD_BITS + 1;   // quotient / root bits, one per cell
   localparam int RW = 2 * QW;          // partial remainder and shift-in bits
   localparam int VW = PW + 1;          // unsigned result before saturation

   localparam logic [VW-1:0] WMAX_V = VW'((64'd1 << (WORD_BITS - 1)) - 64'd1);
   localparam logic [VW-1:0] HALF_V = (FRAC_BITS > 0) ? VW'(64'd1 << (FRAC_BITS - 1)) : '0;

   // operation codes
   localparam logic [3:0] MODE_ADD  = 4'd0;
   localparam logic [3:0] MODE_SUB  = 4'd1;
   localparam logic [3:0] MODE_MUL  = 4'd2;
   localparam logic [3:0] MODE_CDIV = 4'd3;
   localparam logic [3:0] MODE_DIVR = 4'd4;
   localparam logic [3:0] MODE_CONJ = 4'd5;
   localparam logic [3:0] MODE_MAG2 = 4'd6;
   localparam logic [3:0] MODE_MAG  = 4'd7;
   localparam logic [3:0] MODE_EQ   = 4'd8;

   // how the final stage forms a lane's magnitude
   typedef enum logic [2:0] {
      KIND_ZERO,
      KIND_DIRECT,
      KIND_ROUND,
      KIND_DIV,
      KIND_SQRT
   } kind_type;

   typedef struct packed {
      logic [3:0]                  mode;
      logic signed [WORD_BITS-1:0] a_re;
      logic signed [WORD_BITS-1:0] a_im;
      logic signed [WORD_BITS-1:0] b_re;
      logic signed [WORD_BITS-1:0] b_im;
   } req_type;

   typedef struct packed {
      logic signed [WORD_BITS-1:0] re_out;
      logic signed [WORD_BITS-1:0] im_out;
      logic                        equal;
      logic                        overflow;
      logic                        div_zero;
   } rsp_type;

   typedef struct packed {
      kind_type      kind;
      logic          neg;
      logic          big;   // quotient too large for the cells
      logic [PW-1:0] mag;
   } lane_side_type;

   typedef struct packed {
      logic          sq;
      logic          eq;
      logic          dz;
      lane_side_type re;
      lane_side_type im;
   } side_type;

   typedef struct packed {
      logic [RW-1:0] r;
      logic [RW-1:0] src;
      logic [QW-1:0] root;
      logic [PW-1:0] d;
   } lane_type;

   typedef struct packed {
      logic     valid;
      side_type side;
      lane_type re;
      lane_type im;
   } cell_type;

   // one restoring step: a quotient bit, or a root bit when sq is set
   function automatic lane_type cau_step(lane_type l, logic sq);
      logic [RW-1:0] sh;
      logic [RW-1:0] trial;
      logic          ge;
      lane_type      o;
      o     = l;
      sh    = sq ? {l.r[RW-3:0], l.src[RW-1 -: 2]} : {l.r[RW-2:0], l.src[RW-1]};
      trial = sq ? RW'({l.root, 2'b01}) : RW'(l.d);
      ge    = (sh >= trial);
      o.r    = ge ? (sh - trial) : sh;
      o.src  = sq ? {l.src[RW-3:0], 2'b00} : {l.src[RW-2:0], 1'b0};
      o.root = {l.root[QW-2:0], ge};
      return o;
   endfunction

endpackage

>>> design/cau_cell.sv
// One cell of the divide / square-root chain: a step for each lane, then a register.
module cau_cell import cau_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  cell_type up_word,
   output logic     up_ready,
   output cell_type dn_word,
   input  logic     dn_ready
);

   logic     valid_ff;
   cell_type data_ff, data_in;

   assign up_ready = !valid_ff || dn_ready;

   // step both lanes
   always_comb begin
      data_in    = up_word;
      data_in.re = cau_step(up_word.re, up_word.side.sq);
      data_in.im = cau_step(up_word.im, up_word.side.sq);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_word.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_word.valid) begin
         data_ff <= data_in;
      end
   end

   always_comb begin
      dn_word       = data_ff;
      dn_word.valid = valid_ff;
   end

endmodule

>>> design/cau_front.sv
// Front pipeline: products, sums, magnitudes and setup of the cell chain.
module cau_front import cau_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  req_type  req_word,
   output cell_type dn_word,
   input  logic     dn_ready
);

   typedef struct packed {
      logic [3:0]                  mode;
      logic signed [WORD_BITS-1:0] ar;
      logic signed [WORD_BITS-1:0] ai;
      logic signed [WORD_BITS-1:0] br;
      logic signed [WORD_BITS-1:0] bi;
      logic signed [PW-1:0]        m0;
      logic signed [PW-1:0]        m1;
      logic signed [PW-1:0]        m2;
      logic signed [PW-1:0]        m3;
      logic signed [PW-1:0]        m4;
      logic signed [PW-1:0]        m5;
   } s1_type;

   typedef struct packed {
      logic                 sq;
      logic                 eq;
      logic                 dz;
      logic                 negb;
      kind_type             kind_re;
      kind_type             kind_im;
      logic signed [SW-1:0] xs;
      logic signed [SW-1:0] ys;
      logic signed [SW-1:0] ds;
   } s2_type;

   typedef struct packed {
      side_type      side;
      logic [PW-1:0] dmag;
   } s3_type;

   logic     s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic     rdy1, rdy2, rdy3, rdy4;
   s1_type   s1_ff, s1_in;
   s2_type   s2_ff, s2_in;
   s3_type   s3_ff, s3_in;
   cell_type s4_ff, s4_in;

   logic signed [WORD_BITS-1:0] op0, op1;
   logic                        sq_in;
   logic [PW+QW-1:0]            n_re, n_im;

   assign rdy4      = !s4_valid_ff || dn_ready;
   assign rdy3      = !s3_valid_ff || rdy4;
   assign rdy2      = !s2_valid_ff || rdy3;
   assign rdy1      = !s1_valid_ff || rdy2;
   assign req_stall = !rdy1;

   // stage 1: the six products, squares of a in the magnitude modes
   always_comb begin
      sq_in = (req_word.mode == MODE_MAG2) || (req_word.mode == MODE_MAG);
      op0   = sq_in ? req_word.a_re : req_word.b_re;
      op1   = sq_in ? req_word.a_im : req_word.b_im;
      s1_in.mode = req_word.mode;
      s1_in.ar   = req_word.a_re;
      s1_in.ai   = req_word.a_im;
      s1_in.br   = req_word.b_re;
      s1_in.bi   = req_word.b_im;
      s1_in.m0   = PW'(req_word.a_re) * PW'(op0);
      s1_in.m1   = PW'(req_word.a_im) * PW'(op1);
      s1_in.m2   = PW'(req_word.a_re) * PW'(req_word.b_im);
      s1_in.m3   = PW'(req_word.a_im) * PW'(req_word.b_re);
      s1_in.m4   = PW'(req_word.b_re) * PW'(req_word.b_re);
      s1_in.m5   = PW'(req_word.b_im) * PW'(req_word.b_im);
   end

   // stage 2: signed sums per lane and the divisor
   always_comb begin
      s2_in.sq      = (s1_ff.mode == MODE_MAG);
      s2_in.eq      = (s1_ff.mode == MODE_EQ) && (s1_ff.ar == s1_ff.br) && (s1_ff.ai == s1_ff.bi);
      s2_in.dz      = 1'b0;
      s2_in.negb    = 1'b0;
      s2_in.kind_re = KIND_ZERO;
      s2_in.kind_im = KIND_ZERO;
      s2_in.xs      = '0;
      s2_in.ys      = '0;
      s2_in.ds      = '0;
      unique case (s1_ff.mode)
         MODE_ADD: begin
            s2_in.xs = SW'(s1_ff.ar) + SW'(s1_ff.br);
            s2_in.ys = SW'(s1_ff.ai) + SW'(s1_ff.bi);
            s2_in.kind_re = KIND_DIRECT;
            s2_in.kind_im = KIND_DIRECT;
         end
         MODE_SUB: begin
            s2_in.xs = SW'(s1_ff.ar) - SW'(s1_ff.br);
            s2_in.ys = SW'(s1_ff.ai) - SW'(s1_ff.bi);
            s2_in.kind_re = KIND_DIRECT;
            s2_in.kind_im = KIND_DIRECT;
         end
         MODE_MUL: begin
            s2_in.xs = SW'(s1_ff.m0) - SW'(s1_ff.m1);
            s2_in.ys = SW'(s1_ff.m2) + SW'(s1_ff.m3);
            s2_in.kind_re = KIND_ROUND;
            s2_in.kind_im = KIND_ROUND;
         end
         MODE_CDIV: begin
            s2_in.xs = SW'(s1_ff.m0) + SW'(s1_ff.m1);
            s2_in.ys = SW'(s1_ff.m3) - SW'(s1_ff.m2);
            s2_in.ds = SW'(s1_ff.m4) + SW'(s1_ff.m5);
            s2_in.dz = (s1_ff.br == '0) && (s1_ff.bi == '0);
            s2_in.kind_re = s2_in.dz ? KIND_ZERO : KIND_DIV;
            s2_in.kind_im = s2_in.dz ? KIND_ZERO : KIND_DIV;
         end
         MODE_DIVR: begin
            s2_in.xs   = SW'(s1_ff.ar);
            s2_in.ys   = SW'(s1_ff.ai);
            s2_in.ds   = SW'(s1_ff.br);
            s2_in.negb = s1_ff.br[WORD_BITS-1];
            s2_in.dz   = (s1_ff.br == '0);
            s2_in.kind_re = s2_in.dz ? KIND_ZERO : KIND_DIV;
            s2_in.kind_im = s2_in.dz ? KIND_ZERO : KIND_DIV;
         end
         MODE_CONJ: begin
            s2_in.xs = SW'(s1_ff.ar);
            s2_in.ys = -SW'(s1_ff.ai);
            s2_in.kind_re = KIND_DIRECT;
            s2_in.kind_im = KIND_DIRECT;
         end
         MODE_MAG2: begin
            s2_in.xs = SW'(s1_ff.m0) + SW'(s1_ff.m1);
            s2_in.kind_re = KIND_ROUND;
         end
         MODE_MAG: begin
            s2_in.xs = SW'(s1_ff.m0) + SW'(s1_ff.m1);
            s2_in.kind_re = KIND_SQRT;
         end
         default: begin
         end
      endcase
   end

   // stage 3: sign and magnitude
   always_comb begin
      s3_in.side.sq      = s2_ff.sq;
      s3_in.side.eq      = s2_ff.eq;
      s3_in.side.dz      = s2_ff.dz;
      s3_in.side.re.kind = s2_ff.kind_re;
      s3_in.side.re.neg  = s2_ff.xs[SW-1] ^ s2_ff.negb;
      s3_in.side.re.big  = 1'b0;
      s3_in.side.re.mag  = PW'(s2_ff.xs[SW-1] ? -s2_ff.xs : s2_ff.xs);
      s3_in.side.im.kind = s2_ff.kind_im;
      s3_in.side.im.neg  = s2_ff.ys[SW-1] ^ s2_ff.negb;
      s3_in.side.im.big  = 1'b0;
      s3_in.side.im.mag  = PW'(s2_ff.ys[SW-1] ? -s2_ff.ys : s2_ff.ys);
      s3_in.dmag         = PW'(s2_ff.ds[SW-1] ? -s2_ff.ds : s2_ff.ds);
   end

   // stage 4: split the scaled numerator into start remainder and shift-in bits (the radicand alone in root mode)
   always_comb begin
      n_re = {s3_ff.side.re.mag, {QW{1'b0}}} >> (WORD_BITS - FRAC_BITS);
      n_im = {s3_ff.side.im.mag, {QW{1'b0}}} >> (WORD_BITS - FRAC_BITS);
      s4_in       = '0;
      s4_in.valid = s3_valid_ff;
      s4_in.side  = s3_ff.side;
      s4_in.re.d  = s3_ff.dmag;
      s4_in.im.d  = s3_ff.dmag;
      if (s3_ff.side.sq) begin
         s4_in.re.src = RW'(s3_ff.side.re.mag);
      end else begin
         s4_in.re.r   = RW'(n_re[PW+QW-1:QW]);
         s4_in.re.src = {n_re[QW-1:0], {(RW-QW){1'b0}}};
      end
      s4_in.im.r   = RW'(n_im[PW+QW-1:QW]);
      s4_in.im.src = {n_im[QW-1:0], {(RW-QW){1'b0}}};
      s4_in.side.re.big = (n_re[PW+QW-1:QW] >= s3_ff.dmag);
      s4_in.side.im.big = (n_im[PW+QW-1:QW] >= s3_ff.dmag);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         if (rdy1) begin
            s1_valid_ff <= req_valid;
         end
         if (rdy2) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (rdy3) begin
            s3_valid_ff <= s2_valid_ff;
         end
         if (rdy4) begin
            s4_valid_ff <= s3_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1 && req_valid) begin
         s1_ff <= s1_in;
      end
      if (rdy2 && s1_valid_ff) begin
         s2_ff <= s2_in;
      end
      if (rdy3 && s2_valid_ff) begin
         s3_ff <= s3_in;
      end
      if (rdy4 && s3_valid_ff) begin
         s4_ff <= s4_in;
      end
   end

   always_comb begin
      dn_word       = s4_ff;
      dn_word.valid = s4_valid_ff;
   end

endmodule

>>> design/cau_back.sv
// Final stage: rounding, saturation and the output register.
module cau_back import cau_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  cell_type up_word,
   output logic     up_ready,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   output rsp_type  rsp_word
);

   typedef struct packed {
      logic [WORD_BITS-1:0] word;
      logic                 ovf;
   } lane_res_type;

   function automatic lane_res_type lane_finish(lane_side_type s, logic [QW-1:0] root);
      logic [VW-1:0] val;
      logic [VW-1:0] lim;
      lane_res_type  o;
      unique case (s.kind)
         KIND_DIRECT: val = VW'(s.mag);
         KIND_ROUND:  val = (VW'(s.mag) + HALF_V) >> FRAC_BITS;
         KIND_DIV:    val = (VW'(root) + VW'(1)) >> 1;
         KIND_SQRT:   val = VW'(root);
         default:     val = '0;
      endcase
      lim   = s.neg ? (WMAX_V + VW'(1)) : WMAX_V;
      o.ovf = 1'b0;
      if (((s.kind == KIND_DIV) && s.big) || (val > lim)) begin
         o.ovf = 1'b1;
         val   = lim;
      end
      o.word = s.neg ? WORD_BITS'(-val) : WORD_BITS'(val);
      return o;
   endfunction

   logic         rsp_valid_ff;
   rsp_type      rsp_ff, rsp_in;
   lane_res_type res_re, res_im;

   assign up_ready = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      res_re          = lane_finish(up_word.side.re, up_word.re.root);
      res_im          = lane_finish(up_word.side.im, up_word.im.root);
      rsp_in.re_out   = res_re.word;
      rsp_in.im_out   = res_im.word;
      rsp_in.equal    = up_word.side.eq;
      rsp_in.overflow = res_re.ovf | res_im.ovf;
      rsp_in.div_zero = up_word.side.dz;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (up_ready) begin
         rsp_valid_ff <= up_word.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_word.valid) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

endmodule

>>> design/complex_arithmetic_unit.sv
// Complex-number ALU top level: front pipeline, divide/root cell chain, output stage.
// Takes one word per cycle while req_stall is low and returns one result word for
// each, in order, through four front stages (products, sums, magnitudes, divider
// setup), a chain of WORD_BITS+1 cells that each produce one quotient or root bit
// for both lanes, and the rounding/saturation output register. Every mode goes
// through the same chain, so latency does not depend on the mode. The ready path
// is combinational through every stage: an output stall reaches req_stall in the
// same cycle, but only once every stage is full, so empty stages still fill while
// the output waits and the pipe holds 22 words.
module complex_arithmetic_unit import cau_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_word,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_word
);

   cell_type link [QW+1];
   logic     rdy  [QW+1];

   cau_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .dn_word   (link[0]),
      .dn_ready  (rdy[0])
   );

   // one quotient / root bit per cell
   for (genvar k = 0; k < QW; k++) begin : g_cell
      cau_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_word  (link[k]),
         .up_ready (rdy[k]),
         .dn_word  (link[k+1]),
         .dn_ready (rdy[k+1])
      );
   end

   cau_back u_back (
      .clock     (clock),
      .reset     (reset),
      .up_word   (link[QW]),
      .up_ready  (rdy[QW]),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

endmodule
